FILE: rtl/spectrum512_pixel_decoder_macros.svh
// Assertion macros shared by the pixel decoder RTL.
`ifndef SPECTRUM512_PIXEL_DECODER_MACROS_SVH
`define SPECTRUM512_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spd assertion failed");

// Next-cycle implication, checked out of reset.
`define SPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spd assertion failed");

`endif

FILE: rtl/spd_pkg.sv
// Package with types, constants and bank selection for the pixel decoder.
package spd_pkg;

    localparam int NUM_LINES_DEF  = 200;
    localparam int SLOTS_PER_LINE = 48;
    localparam int ENTRY_W        = 9;

    localparam logic [8:0] BANK_SPAN = 9'd160;

    typedef enum logic {
        REQ_PAL_WRITE = 1'b0,
        REQ_DECODE    = 1'b1
    } req_type_t;

    // Per-pixel side data that travels alongside the palette read.
    typedef struct packed {
        logic [8:0] column;
        logic       last;
        logic       black;
    } pix_meta_t;

    // Pick the palette slot of colour c at screen column col.
    function automatic logic [5:0] bank_index(input logic [3:0] c, input logic [8:0] col);
        logic [8:0] c10;
        logic [8:0] x1;
        logic [5:0] idx;
        c10 = {2'b00, c, 3'b000} + {4'b0000, c, 1'b0};
        x1  = c[0] ? (c10 - 9'd5) : (c10 + 9'd1);
        if (col >= x1 + BANK_SPAN) begin
            idx = {2'b10, c};
        end else if (col >= x1) begin
            idx = {2'b01, c};
        end else begin
            idx = {2'b00, c};
        end
        return idx;
    endfunction

endpackage

FILE: rtl/spd_pal_ram.sv
// Single-port palette memory with registered read data.
module spd_pal_ram #(
    parameter int DEPTH = 9600,
    parameter int AW    = 14,
    parameter int DW    = 9
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/spectrum512_pixel_decoder.sv
// Pixel decoder: four-bitplane groups to 3-bit RGB with per-line palettes.
// Palette write: no output word.
// Group: 16 output words, one per cycle unless m_ready stalls the output.
// One palette read per pixel, single RAM port; next group accepted with the last read.
// Reset (aresetn low, synchronous) clears control only; palette contents stay
// undefined until written, line 0 and lines past the end always read black.
module spectrum512_pixel_decoder #(
    parameter int NUM_LINES = spd_pkg::NUM_LINES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_line,
    input  logic [5:0]  s_slot,
    input  logic [15:0] s_color_word,
    input  logic [4:0]  s_group,
    input  logic [15:0] s_plane0,
    input  logic [15:0] s_plane1,
    input  logic [15:0] s_plane2,
    input  logic [15:0] s_plane3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_red,
    output logic [2:0]  m_green,
    output logic [2:0]  m_blue,
    output logic [8:0]  m_column,
    output logic        m_last_pixel
);
    import spd_pkg::*;

    `include "spectrum512_pixel_decoder_macros.svh"

    localparam int DEPTH = NUM_LINES * SLOTS_PER_LINE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Current item
    logic        cur_valid_reg, cur_valid_next;
    logic        cur_type_reg;
    logic [7:0]  cur_line_reg;
    logic [5:0]  cur_slot_reg;
    logic [15:0] cur_color_reg;
    logic [4:0]  cur_group_reg;
    logic [15:0] cur_p0_reg, cur_p1_reg, cur_p2_reg, cur_p3_reg;
    logic [3:0]  cnt_reg, cnt_next;

    // Read stage and output register
    logic        b_valid_reg;
    pix_meta_t   b_meta_reg, b_meta_next;
    logic        m_valid_reg;
    logic [2:0]  m_red_reg, m_green_reg, m_blue_reg;
    logic [8:0]  m_column_reg;
    logic        m_last_reg;

    logic               adv;
    logic               issue_read;
    logic               do_write;
    logic               retire;
    logic               accept;
    logic               line_ok;
    logic [3:0]         bit_sel;
    logic [3:0]         pix_c;
    logic [8:0]         pix_col;
    logic [5:0]         idx;
    logic [15:0]        addr_full;
    logic [AW-1:0]      ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    assign adv     = !m_valid_reg || m_ready;
    assign line_ok = (cur_line_reg != 8'd0) && (int'(cur_line_reg) < NUM_LINES);

    assign bit_sel = 4'd15 - cnt_reg;
    assign pix_c   = {cur_p3_reg[bit_sel], cur_p2_reg[bit_sel],
                      cur_p1_reg[bit_sel], cur_p0_reg[bit_sel]};
    assign pix_col = {cur_group_reg, cnt_reg};

    always_comb begin
        idx        = bank_index(pix_c, pix_col);
        issue_read = cur_valid_reg && (cur_type_reg == REQ_DECODE) && adv;
        do_write   = cur_valid_reg && (cur_type_reg == REQ_PAL_WRITE) && line_ok
                     && (int'(cur_slot_reg) < SLOTS_PER_LINE);
        retire     = cur_valid_reg && ((cur_type_reg == REQ_PAL_WRITE)
                     || (issue_read && cnt_reg == 4'd15));
        s_ready    = !cur_valid_reg || retire;
        accept     = s_valid && s_ready;

        addr_full = 16'({cur_line_reg, 5'b00000}) + 16'({cur_line_reg, 4'b0000})
                    + (do_write ? 16'(cur_slot_reg) : 16'(idx));
        ram_addr  = AW'(addr_full);
        ram_wdata = {cur_color_reg[10:8], cur_color_reg[6:4], cur_color_reg[2:0]};

        cur_valid_next = accept ? 1'b1 : (retire ? 1'b0 : cur_valid_reg);
        priority if (accept) begin
            cnt_next = 4'd0;
        end else if (issue_read) begin
            cnt_next = cnt_reg + 4'd1;
        end else begin
            cnt_next = cnt_reg;
        end

        b_meta_next.column = pix_col;
        b_meta_next.last   = (cnt_reg == 4'd15);
        b_meta_next.black  = !line_ok;
    end

    spd_pal_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (ENTRY_W)
    ) u_pal_ram (
        .aclk  (aclk),
        .we    (do_write),
        .re    (issue_read),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            cnt_reg       <= cnt_next;
            if (adv) begin
                b_valid_reg <= issue_read;
                m_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_type_reg  <= s_req_type;
            cur_line_reg  <= s_line;
            cur_slot_reg  <= s_slot;
            cur_color_reg <= s_color_word;
            cur_group_reg <= s_group;
            cur_p0_reg    <= s_plane0;
            cur_p1_reg    <= s_plane1;
            cur_p2_reg    <= s_plane2;
            cur_p3_reg    <= s_plane3;
        end
        if (adv) begin
            b_meta_reg   <= b_meta_next;
            // Force black for line 0 and lines past the end.
            m_red_reg    <= b_meta_reg.black ? 3'd0 : ram_rdata[8:6];
            m_green_reg  <= b_meta_reg.black ? 3'd0 : ram_rdata[5:3];
            m_blue_reg   <= b_meta_reg.black ? 3'd0 : ram_rdata[2:0];
            m_column_reg <= b_meta_reg.column;
            m_last_reg   <= b_meta_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red        = m_red_reg;
    assign m_green      = m_green_reg;
    assign m_blue       = m_blue_reg;
    assign m_column     = m_column_reg;
    assign m_last_pixel = m_last_reg;

    `SPD_ASSERT_NOW(a_port_exclusive, aclk, aresetn, do_write, !issue_read)
    `SPD_ASSERT_NOW(a_last_col, aclk, aresetn, m_valid && m_last_pixel, m_column[3:0] == 4'hF)
    `SPD_ASSERT_NEXT(a_cnt_step, aclk, aresetn, issue_read && cnt_reg != 4'd15,
        cur_valid_reg && cnt_reg == $past(cnt_reg) + 4'd1)

endmodule

FILE: tb/spectrum512_pixel_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Spectrum 512 pixel decoder: palette writes and group decodes.
module spectrum512_pixel_decoder_tb;
    import spd_pkg::*;

    localparam int LINES        = NUM_LINES_DEF;
    localparam int SLOTS        = SLOTS_PER_LINE;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 50;
    localparam int ITEM_BUDGET  = 120;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        req_type_t   kind;
        logic [7:0]  line;
        logic [5:0]  slot;
        logic [15:0] color_word;
        logic [4:0]  group;
        logic [15:0] plane0;
        logic [15:0] plane1;
        logic [15:0] plane2;
        logic [15:0] plane3;
    } in_word_t;

    typedef struct packed {
        logic [2:0] red;
        logic [2:0] green;
        logic [2:0] blue;
        logic [8:0] column;
        logic       last_pixel;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [7:0]  s_line = '0;
    logic [5:0]  s_slot = '0;
    logic [15:0] s_color_word = '0;
    logic [4:0]  s_group = '0;
    logic [15:0] s_plane0 = '0;
    logic [15:0] s_plane1 = '0;
    logic [15:0] s_plane2 = '0;
    logic [15:0] s_plane3 = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_red;
    logic [2:0]  m_green;
    logic [2:0]  m_blue;
    logic [8:0]  m_column;
    logic        m_last_pixel;

    in_word_t   pending_words[$];
    pixel_t     expected_pixels[$];
    logic [8:0] pal_shadow [LINES*SLOTS];
    bit         written_map [LINES*SLOTS];

    int n_words_queued  = 0;
    int n_words_offered = 0;
    int n_words_taken   = 0;
    int n_pal_writes    = 0;
    int n_decodes       = 0;
    int n_pixels_seen   = 0;
    int n_fail          = 0;
    int cycle_count     = 0;
    bit hold_req        = 1'b0;

    spectrum512_pixel_decoder dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still expected",
                     cycle_count, expected_pixels.size());
            $display("spectrum512_pixel_decoder_tb: FAIL");
            $finish;
        end
    end

    // Palette slot picked by colour c at column col (three banks, switch at x1 and x1+160).
    function automatic int bank_slot(int c, int col);
        int x1;
        x1 = (c % 2 == 1) ? 10 * c - 5 : 10 * c + 1;
        if (col >= x1 + 160) return c + 32;
        if (col >= x1) return c + 16;
        return c;
    endfunction

    function automatic int color_at(in_word_t w, int i);
        int b;
        b = 15 - i;
        return {w.plane3[b], w.plane2[b], w.plane1[b], w.plane0[b]};
    endfunction

    // Update the palette shadow or queue the sixteen pixels of a group.
    task automatic apply_word(in_word_t w);
        pixel_t     px;
        logic [8:0] entry;
        int         col;
        if (w.kind == REQ_PAL_WRITE) begin
            if (w.line != 0 && w.line < LINES && w.slot < SLOTS)
                pal_shadow[w.line * SLOTS + w.slot] =
                    {w.color_word[10:8], w.color_word[6:4], w.color_word[2:0]};
            n_pal_writes++;
        end else begin
            for (int i = 0; i < 16; i++) begin
                col = w.group * 16 + i;
                if (w.line == 0 || w.line >= LINES)
                    entry = '0;
                else
                    entry = pal_shadow[w.line * SLOTS + bank_slot(color_at(w, i), col)];
                px.red        = entry[8:6];
                px.green      = entry[5:3];
                px.blue       = entry[2:0];
                px.column     = col[8:0];
                px.last_pixel = (i == 15);
                expected_pixels.push_back(px);
            end
            n_decodes++;
        end
    endtask

    task automatic push_write(int line, int slot, logic [15:0] color);
        in_word_t w;
        w.kind       = REQ_PAL_WRITE;
        w.line       = line[7:0];
        w.slot       = slot[5:0];
        w.color_word = color;
        w.group      = 5'($urandom);
        w.plane0     = 16'($urandom);
        w.plane1     = 16'($urandom);
        w.plane2     = 16'($urandom);
        w.plane3     = 16'($urandom);
        if (line != 0 && line < LINES && slot < SLOTS)
            written_map[line * SLOTS + slot] = 1'b1;
        pending_words.push_back(w);
        n_words_queued++;
    endtask

    // Queue a group decode, first writing any palette entry the group would read that has never been written.
    task automatic push_decode(int line, int group, logic [15:0] p0, logic [15:0] p1,
                               logic [15:0] p2, logic [15:0] p3);
        in_word_t w;
        int       idx;
        w.kind       = REQ_DECODE;
        w.line       = line[7:0];
        w.slot       = 6'($urandom);
        w.color_word = 16'($urandom);
        w.group      = group[4:0];
        w.plane0     = p0;
        w.plane1     = p1;
        w.plane2     = p2;
        w.plane3     = p3;
        if (line != 0 && line < LINES) begin
            for (int i = 0; i < 16; i++) begin
                idx = bank_slot(color_at(w, i), group * 16 + i);
                if (!written_map[line * SLOTS + idx])
                    push_write(line, idx, 16'($urandom));
            end
        end
        pending_words.push_back(w);
        n_words_queued++;
    endtask

    task automatic push_random_word();
        int r;
        int line;
        r = $urandom_range(0, 99);
        line = ($urandom_range(0, 7) == 0) ? $urandom_range(1, LINES - 1)
                                           : $urandom_range(1, 4);
        if (r < 25) begin
            push_write(line, $urandom_range(0, SLOTS - 1), 16'($urandom));
        end else if (r < 35) begin
            push_write($urandom_range(0, 255), $urandom_range(0, 63), 16'($urandom));
        end else if (r < 90) begin
            push_decode(line, ($urandom_range(0, 5) == 0) ? $urandom_range(20, 31)
                                                           : $urandom_range(0, 19),
                        16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            push_decode(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(LINES, 255),
                        $urandom_range(0, 31), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || n_words_taken != n_words_offered ||
               expected_pixels.size() != 0)
            @(posedge aclk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 4;
    int gap_left   = 0;
    always @(negedge aclk) begin
        in_word_t w;
        if (aresetn && n_words_taken == n_words_offered) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                s_req_type   <= w.kind;
                s_line       <= w.line;
                s_slot       <= w.slot;
                s_color_word <= w.color_word;
                s_group      <= w.group;
                s_plane0     <= w.plane0;
                s_plane1     <= w.plane1;
                s_plane2     <= w.plane2;
                s_plane3     <= w.plane3;
                s_valid      <= 1'b1;
                n_words_offered++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern picked at random from three modes, plus one long hold on request.
    int rx_cycle  = 0;
    int rx_mode   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge aclk) begin
        rx_cycle++;
        if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (rx_cycle % 97 == 0)
            rx_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                default: m_ready <= (rx_cycle % 7) > 2;
            endcase
        end
    end

    always @(posedge aclk) begin
        in_word_t w;
        pixel_t   got;
        pixel_t   want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                w = '{req_type_t'(s_req_type), s_line, s_slot, s_color_word, s_group,
                      s_plane0, s_plane1, s_plane2, s_plane3};
                apply_word(w);
                n_words_taken++;
            end
            if (m_valid && m_ready) begin
                got = '{m_red, m_green, m_blue, m_column, m_last_pixel};
                if (expected_pixels.size() == 0) begin
                    if (n_fail < REPORT_MAX)
                        $display("unexpected pixel: rgb %0d/%0d/%0d column %0d last %0d",
                                 got.red, got.green, got.blue, got.column, got.last_pixel);
                    n_fail++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.column !== want.column ||
                        got.last_pixel !== want.last_pixel) begin
                        if (n_fail < REPORT_MAX)
                            $display({"pixel mismatch: expected rgb %0d/%0d/%0d col %0d ",
                                      "last %0d, got rgb %0d/%0d/%0d col %0d last %0d"},
                                     want.red, want.green, want.blue, want.column,
                                     want.last_pixel, got.red, got.green, got.blue,
                                     got.column, got.last_pixel);
                        n_fail++;
                    end
                end
                n_pixels_seen++;
            end
        end
    end

    initial begin
        int leftover;
        int half_mark;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: ignored writes, black lines, banks at both ends, groups past the line.
        push_write(0, 5, 16'hFFFF);
        push_write(LINES, 3, 16'h0777);
        push_write(255, 47, 16'hFFFF);
        push_write(1, SLOTS, 16'hFFFF);
        push_write(1, 63, 16'h0000);
        push_write(1, 0, 16'h0000);
        push_write(1, 16, 16'hF888);
        push_write(LINES - 1, 47, 16'hFFFF);
        push_decode(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_decode(255, 31, 16'hA5C3, 16'h3C5A, 16'hFFFF, 16'h0000);
        push_decode(LINES, 19, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        push_decode(1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_decode(LINES - 1, 19, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_decode(1, 9, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
        push_decode(2, 0, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
        push_decode(2, 19, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
        push_decode(3, 31, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
        push_write(1, 0, 16'hFFFF);
        push_decode(1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        wait_drained();

        // Split the remaining word budget over two random phases.
        half_mark = (n_words_queued + ITEM_BUDGET) / 2;
        while (n_words_queued < half_mark)
            push_random_word();
        // Hold the result side while the input side keeps offering words.
        hold_req = 1'b1;
        wait_drained();

        while (n_words_queued < ITEM_BUDGET)
            push_random_word();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        leftover = expected_pixels.size();
        if (leftover != 0)
            $display("%0d expected pixels never arrived", leftover);
        $display("run covered %0d palette writes and %0d group decodes, %0d pixels checked",
                 n_pal_writes, n_decodes, n_pixels_seen);
        if (n_fail == 0 && leftover == 0) begin
            $display("spectrum512_pixel_decoder_tb: PASS");
        end else begin
            $display("%0d pixel failures", n_fail);
            $display("spectrum512_pixel_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule
